// ===== hw/rtl/atgs_pkg.sv =====
// ----------------------------------------------------------------------------
// atgs_pkg
// Shared constants for the tilt angle and gyro rate core.
// ----------------------------------------------------------------------------
`default_nettype none
package atgs_pkg;
  localparam int CordicSteps = 24;
  localparam int SqrtSteps   = 24;
  localparam logic signed [33:0] Deg180Units = 34'sd1509949440;
  // ceil(2^31 / 131)
  localparam logic [23:0] RateRecip = 24'd16393005;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] v;
    begin
      case (i)
        5'd0: v = 34'sd377487360;
        5'd1: v = 34'sd222843801;
        5'd2: v = 34'sd117744544;
        5'd3: v = 34'sd59768969;
        5'd4: v = 34'sd30000467;
        5'd5: v = 34'sd15014858;
        5'd6: v = 34'sd7509261;
        5'd7: v = 34'sd3754860;
        5'd8: v = 34'sd1877459;
        5'd9: v = 34'sd938733;
        5'd10: v = 34'sd469367;
        5'd11: v = 34'sd234684;
        5'd12: v = 34'sd117342;
        5'd13: v = 34'sd58671;
        5'd14: v = 34'sd29335;
        5'd15: v = 34'sd14668;
        5'd16: v = 34'sd7334;
        5'd17: v = 34'sd3667;
        5'd18: v = 34'sd1833;
        5'd19: v = 34'sd917;
        5'd20: v = 34'sd458;
        5'd21: v = 34'sd229;
        5'd22: v = 34'sd115;
        5'd23: v = 34'sd57;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // right shift rounding toward zero
  function automatic logic signed [43:0] shr_tz(input logic signed [43:0] v,
                                                input logic [4:0] k);
    logic [43:0] a;
    logic [43:0] s;
    begin
      a = v[43] ? 44'(-v) : v;
      s = a >> k;
      return v[43] ? 44'(-s) : 44'(s);
    end
  endfunction

  // round(|g|*128/131) by reciprocal multiplication, sign restored after
  function automatic logic signed [15:0] rate_scale(input logic signed [15:0] g);
    logic [15:0] m;
    logic [22:0] a;
    logic [46:0] p;
    logic [15:0] q;
    begin
      m = g[15] ? 16'(-g) : 16'(g);
      a = {m, 7'd0} + 23'd65;
      p = 47'(a) * 47'(RateRecip);
      q = p[46:31];
      return g[15] ? 16'(-q) : q;
    end
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/atgs_cordic.sv =====
// ----------------------------------------------------------------------------
// atgs_cordic
// Pipelined CORDIC vectoring atan2, one step per stage, 1/128 degree out.
// ----------------------------------------------------------------------------
`default_nettype none
module atgs_cordic
  import atgs_pkg::*;
#(
  parameter logic [15:0] Lim = 16'd23040
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [43:0]  y_in,
  input  wire logic signed [43:0]  x_in,
  output logic signed [15:0]       angle
);
  logic signed [43:0] x_r [CordicSteps+1];
  logic signed [43:0] y_r [CordicSteps+1];
  logic signed [33:0] z_r [CordicSteps+1];
  logic               zero_r [CordicSteps+1];
  logic signed [15:0] angle_r;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[43]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= y_in[43] ? -Deg180Units : Deg180Units;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][43] && y_r[i] != '0) begin
          x_r[i+1] <= x_r[i] + shr_tz(y_r[i], 5'(i));
          y_r[i+1] <= y_r[i] - shr_tz(x_r[i], 5'(i));
          z_r[i+1] <= z_r[i] + atan_entry(5'(i));
        end else if (y_r[i][43]) begin
          x_r[i+1] <= x_r[i] - shr_tz(y_r[i], 5'(i));
          y_r[i+1] <= y_r[i] + shr_tz(x_r[i], 5'(i));
          z_r[i+1] <= z_r[i] - atan_entry(5'(i));
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  logic [33:0] za;
  logic [17:0] q;
  logic signed [18:0] qs;
  always_comb begin
    za = z_r[CordicSteps][33] ? 34'(-z_r[CordicSteps]) : 34'(z_r[CordicSteps]);
    q  = 18'((za + 34'd32768) >> 16);
    qs = z_r[CordicSteps][33] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (qs > $signed({3'd0, Lim})) qs = $signed({3'd0, Lim});
    if (qs < -$signed({3'd0, Lim})) qs = -$signed({3'd0, Lim});
  end

  always_ff @(posedge clk) begin
    if (en) angle_r <= zero_r[CordicSteps] ? '0 : 16'(qs);
  end
  assign angle = angle_r;
endmodule
`default_nettype wire

// ===== hw/rtl/accel_tilt_angles_gyro_scaling_core.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles_gyro_scaling_core
// Six-axis sample in, gyro rates and pitch/roll tilt angles out.
// ----------------------------------------------------------------------------
// in_tdata (96 bits): accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z.
// out_tdata (80 bits): rate_x, rate_y, rate_z, pitch_angle, roll_angle, pad.
// One sample per cycle while the output is not stalled. Pipeline: 1 input
// register, 24 square-root stages (one result bit each), 1 operand stage,
// 25 CORDIC stages and one rounding stage, 52 register stages in all. The
// whole pipe advances when the output register is empty or being taken, so
// a stall freezes every stage and nothing is lost or repeated. Reset clears
// all valid bits.
// ----------------------------------------------------------------------------
`default_nettype none
module accel_tilt_angles_gyro_scaling_core
  import atgs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,  // accel_x,accel_y,accel_z,gyro_x,gyro_y,gyro_z
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata  // rate_x,rate_y,rate_z,pitch_angle,roll_angle
);
  localparam int Depth = SqrtSteps + 1 + CordicSteps + 3;

  logic en;
  logic [Depth-1:0] vld_r;
  assign en = !vld_r[Depth-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-2:0], in_tvalid};
  end

  logic [47:0] rate_d [SqrtSteps+1+CordicSteps+2];
  logic [47:0] rem_r [SqrtSteps+1];
  logic [23:0] root_r [SqrtSteps+1];
  logic signed [15:0] sax_r [SqrtSteps+1], say_r [SqrtSteps+1], saz_r [SqrtSteps+1];

  // stage 0: register input, squares
  always_ff @(posedge clk) begin
    if (en) begin
      sax_r[0]  <= in_tdata[15:0];
      say_r[0]  <= in_tdata[31:16];
      saz_r[0]  <= in_tdata[47:32];
      rem_r[0]  <= {32'($signed(in_tdata[31:16]) * $signed(in_tdata[31:16])) +
                    32'($signed(in_tdata[47:32]) * $signed(in_tdata[47:32])), 16'd0};
      root_r[0] <= '0;
      rate_d[0] <= {rate_scale(in_tdata[95:80]), rate_scale(in_tdata[79:64]),
                    rate_scale(in_tdata[63:48])};
    end
  end

  // restoring square root of sq<<16, one result bit per stage
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic [49:0] trial;
    logic [49:0] part;
    assign part  = 50'(rem_r[i] >> (2*(SqrtSteps-1-i)));
    assign trial = 50'({root_r[i], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        if (part >= trial) begin
          rem_r[i+1]  <= rem_r[i] - 48'(trial << (2*(SqrtSteps-1-i)));
          root_r[i+1] <= {root_r[i][22:0], 1'b1};
        end else begin
          rem_r[i+1]  <= rem_r[i];
          root_r[i+1] <= {root_r[i][22:0], 1'b0};
        end
        sax_r[i+1] <= sax_r[i];
        say_r[i+1] <= say_r[i];
        saz_r[i+1] <= saz_r[i];
        rate_d[i+1] <= rate_d[i];
      end
    end
  end

  // operand stage
  logic signed [43:0] py_r, px_r, ry_r, rx_r;
  always_ff @(posedge clk) begin
    if (en) begin
      py_r <= 44'(sax_r[SqrtSteps]) <<< 24;
      px_r <= $signed({4'd0, root_r[SqrtSteps], 16'd0});
      ry_r <= 44'(say_r[SqrtSteps]) <<< 24;
      rx_r <= 44'(saz_r[SqrtSteps]) <<< 24;
      rate_d[SqrtSteps+1] <= rate_d[SqrtSteps];
    end
  end
  for (genvar i = SqrtSteps+1; i < SqrtSteps+2+CordicSteps; i++) begin : g_rd
    always_ff @(posedge clk) if (en) rate_d[i+1] <= rate_d[i];
  end

  logic signed [15:0] pitch, roll;
  logic [47:0] rate_o_r;
  atgs_cordic #(.Lim(16'd11520)) u_pitch (
    .clk, .en, .y_in(py_r), .x_in(px_r), .angle(pitch));
  atgs_cordic #(.Lim(16'd23040)) u_roll (
    .clk, .en, .y_in(ry_r), .x_in(rx_r), .angle(roll));
  always_ff @(posedge clk) if (en) rate_o_r <= rate_d[SqrtSteps+2+CordicSteps];

  assign out_tvalid = vld_r[Depth-1];
  assign out_tdata  = {1'b0, roll, pitch[14:0], rate_o_r};
endmodule
`default_nettype wire

// ===== hw/rtl/atgs_checker.sv =====
// ----------------------------------------------------------------------------
// atgs_checker
// Port-level checks for the tilt angle core.
// ----------------------------------------------------------------------------
`default_nettype none
module atgs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |-> out_tvalid && !out_tready) else $error("stall");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[79]) else $error("pad");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("rst");
endmodule
bind accel_tilt_angles_gyro_scaling_core atgs_checker u_chk (.*);
`default_nettype wire

// ===== test/atgs_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atgs_result_checker
// Watches both streams of the tilt and rate core, computes the expected
// rates and angles for every accepted sample and compares each result.
// ----------------------------------------------------------------------------
module atgs_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  output int          n_fail,
  output int          n_pending
);
  typedef struct packed {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] rz;
    logic [15:0] ry;
    logic [15:0] rx;
  } tilt_rates_t;

  tilt_rates_t awaited_q[$];

  localparam longint HalfTurn = 64'sd1509949440;
  longint atan_steps[24] = '{
    377487360, 222843801, 117744544, 59768969, 30000467,
    15014858, 7509261, 3754860, 1877459, 938733, 469367,
    234684, 117342, 58671, 29335, 14668, 7334, 3667,
    1833, 917, 458, 229, 115, 57
  };

  function automatic longint trunc_shift(longint v, int k);
    if (v >= 0) return v >>> k;
    return -((-v) >>> k);
  endfunction

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint y, longint x, longint lim);
    longint z, dx, dy, a, q;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 24; i++) begin
      dx = trunc_shift(y, i);
      dy = trunc_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_steps[i];
      end else if (y < 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end
    end
    a = (z < 0) ? -z : z;
    q = (a + 32768) >>> 16;
    if (z < 0) q = -q;
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic logic [15:0] gyro_to_rate(logic signed [15:0] g);
    longint n, a, q;
    n = longint'(g) * 128;
    a = (n < 0) ? -n : n;
    q = (a + 65) / 131;
    return 16'((n < 0) ? -q : q);
  endfunction

  function automatic tilt_rates_t tilt_and_rates(logic [95:0] d);
    tilt_rates_t r;
    longint ax, ay, az, mag;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    mag = floor_sqrt(longint'(ay * ay + az * az) << 16);
    r.rx = gyro_to_rate(d[63:48]);
    r.ry = gyro_to_rate(d[79:64]);
    r.rz = gyro_to_rate(d[95:80]);
    r.pitch = 15'(vector_angle(ax * 16777216, mag * 65536, 11520));
    r.roll = 16'(vector_angle(ay * 16777216, az * 16777216, 23040));
    return r;
  endfunction

  always_ff @(posedge clk) begin
    tilt_rates_t got, want;
    if (!rst_n) begin
      n_fail <= 0;
      n_pending <= 0;
    end else begin
      if (in_tvalid && in_tready) awaited_q.push_back(tilt_and_rates(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[78:0];
        if (awaited_q.size() == 0) begin
          if (n_fail < 10) $display("unexpected result %h", out_tdata);
          n_fail <= n_fail + 1;
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            if (n_fail < 10)
              $display("rates %h %h %h pitch %h roll %h, got %h %h %h pitch %h roll %h",
                       want.rx, want.ry, want.rz, want.pitch, want.roll,
                       got.rx, got.ry, got.rz, got.pitch, got.roll);
            n_fail <= n_fail + 1;
          end
        end
      end
      n_pending <= awaited_q.size();
    end
  end
endmodule

// ===== test/tb_accel_tilt_angles_gyro_scaling_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles_gyro_scaling_core
// Drives directed and random six-axis samples through the core under
// varying back-pressure and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles_gyro_scaling_core;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  int n_fail, n_pending;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles = 0;

  accel_tilt_angles_gyro_scaling_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  atgs_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .n_fail(n_fail), .n_pending(n_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: long hold-offs counted here, otherwise random idling
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(64)) - 32);
      3: return 16'(int'($urandom_range(33000)) - 16500);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [15:0] ax, ay, az, gx, gy, gz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {gz, gy, gx, az, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic [15:0] a[6];
    repeat (count) begin
      foreach (a[k]) a[k] = pick_axis();
      send_sample(a[0], a[1], a[2], a[3], a[4], a[5]);
    end
  endtask

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // zeros, extremes, origin angles and the negative axis cases
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h4000, 16'h0000, 16'h0000, 16'h0001, 16'hffff, 16'h0041);
    send_sample(16'hc000, 16'h0000, 16'h0000, 16'h0083, 16'hff7d, 16'hffbf);
    send_sample(16'h0000, 16'h0000, 16'hc000, 16'h0042, 16'hffbe, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0001, 16'hffff, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0001, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);

    // long receiver hold-off while samples keep coming
    hold_cycles = 200;
    send_random(150);
    in_tvalid <= 1'b0;
    while (n_pending != 0) @(negedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 77;
    send_random(550);
    send_idle_pct = 77;
    recv_idle_pct = 26;
    send_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(550);
    in_tvalid <= 1'b0;

    while (n_pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
